// ----- sv/obuss_pkg.sv -----
// ----------------------------------------------------------------------------
// obuss_pkg
// Shared types and constants for the AV1 OBU stream splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package obuss_pkg;

    // packed output beat: obu_type .. payload_len, zero fill to whole bytes
    localparam int OUT_TDATA_W   = 104;
    localparam int RES_FIFO_DEPTH = 8;

    typedef enum logic [2:0] {
        PH_HDR   = 3'd0,
        PH_EXT   = 3'd1,
        PH_SIZE  = 3'd2,
        PH_PAY   = 3'd3,
        PH_DRAIN = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_OBU        = 3'd0,
        ST_OK         = 3'd1,
        ST_HDR_TRUNC  = 3'd2,
        ST_NO_SIZE    = 3'd3,
        ST_SIZE_TRUNC = 3'd4,
        ST_SIZE_LONG  = 3'd5,
        ST_OVERRUN    = 3'd6
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [3:0]  obu_type;
        logic [31:0] header_pos;
        logic [1:0]  header_len;
        logic [31:0] payload_pos;
        logic [31:0] payload_len;
        logic        final_result;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } step_out_t;

endpackage

`default_nettype wire

// ----- sv/obuss_parser.sv -----
// ----------------------------------------------------------------------------
// obuss_parser
// Per-byte OBU header / leb128 size / payload tracking, up to two results.
// ----------------------------------------------------------------------------
`default_nettype none

module obuss_parser #(
    parameter int POS_WIDTH      = 32,
    parameter int SIZE_MAX_BYTES = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic [7:0]           in_byte,
    input  wire logic                 in_last,
    output obuss_pkg::step_out_t      step
);
    import obuss_pkg::*;

    localparam int ACC_W = 7 * SIZE_MAX_BYTES;
    localparam int IDX_W = (SIZE_MAX_BYTES > 1) ? $clog2(SIZE_MAX_BYTES) : 1;
    localparam int CMP_W = (ACC_W > POS_WIDTH) ? ACC_W : POS_WIDTH;

    phase_t               phase_reg, phase_next;
    logic [POS_WIDTH-1:0] offset_reg, offset_next;
    logic [3:0]           type_reg, type_next;
    logic [POS_WIDTH-1:0] hpos_reg, hpos_next;
    logic [1:0]           hlen_reg, hlen_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [POS_WIDTH-1:0] rem_reg, rem_next;
    logic [POS_WIDTH-1:0] ppos_reg, ppos_next;
    logic                 nosize_reg, nosize_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR;
            offset_reg <= '0;
            type_reg   <= '0;
            hpos_reg   <= '0;
            hlen_reg   <= 2'd1;
            acc_reg    <= '0;
            idx_reg    <= '0;
            rem_reg    <= '0;
            ppos_reg   <= '0;
            nosize_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            type_reg   <= type_next;
            hpos_reg   <= hpos_next;
            hlen_reg   <= hlen_next;
            acc_reg    <= acc_next;
            idx_reg    <= idx_next;
            rem_reg    <= rem_next;
            ppos_reg   <= ppos_next;
            nosize_reg <= nosize_next;
        end
    end

    logic [POS_WIDTH-1:0] off_inc;
    logic [ACC_W-1:0]     acc_upd;
    logic [CMP_W-1:0]     acc_wide;
    logic                 too_big;
    logic [POS_WIDTH-1:0] rem_dec;

    assign off_inc  = offset_reg + POS_WIDTH'(1);
    assign acc_wide = CMP_W'(acc_upd);
    assign too_big  = (acc_wide >> POS_WIDTH) != '0;
    assign rem_dec  = rem_reg - POS_WIDTH'(1);

    // seven size bits land in the group picked by the byte index
    always_comb
    begin
        acc_upd = acc_reg;
        for (int i = 0; i < SIZE_MAX_BYTES; i++)
        begin
            if (idx_reg == IDX_W'(i))
            begin
                acc_upd[7*i +: 7] = acc_reg[7*i +: 7] | in_byte[6:0];
            end
        end
    end

    always_comb
    begin
        logic    err;
        status_t err_code;
        logic    done;

        err         = 1'b0;
        err_code    = ST_OBU;
        done        = 1'b0;
        phase_next  = phase_reg;
        offset_next = offset_reg;
        type_next   = type_reg;
        hpos_next   = hpos_reg;
        hlen_next   = hlen_reg;
        acc_next    = acc_reg;
        idx_next    = idx_reg;
        rem_next    = rem_reg;
        ppos_next   = ppos_reg;
        nosize_next = nosize_reg;
        step        = '0;

        if (in_valid)
        begin
            case (phase_reg)
                PH_HDR:
                begin
                    type_next   = in_byte[6:3];
                    hpos_next   = offset_reg;
                    hlen_next   = in_byte[2] ? 2'd2 : 2'd1;
                    nosize_next = ~in_byte[1];
                    acc_next    = '0;
                    idx_next    = '0;
                    if (in_byte[2])
                    begin
                        if (in_last)
                        begin
                            err      = 1'b1;
                            err_code = ST_HDR_TRUNC;
                        end
                        else
                        begin
                            phase_next = PH_EXT;
                        end
                    end
                    else if (!in_byte[1])
                    begin
                        err      = 1'b1;
                        err_code = ST_NO_SIZE;
                    end
                    else if (in_last)
                    begin
                        err      = 1'b1;
                        err_code = ST_SIZE_TRUNC;
                    end
                    else
                    begin
                        phase_next = PH_SIZE;
                    end
                end
                PH_EXT:
                begin
                    if (nosize_reg)
                    begin
                        err      = 1'b1;
                        err_code = ST_NO_SIZE;
                    end
                    else if (in_last)
                    begin
                        err      = 1'b1;
                        err_code = ST_SIZE_TRUNC;
                    end
                    else
                    begin
                        phase_next = PH_SIZE;
                    end
                end
                PH_SIZE:
                begin
                    acc_next = acc_upd;
                    if (in_byte[7])
                    begin
                        // overlong wins over truncation on the same byte
                        if (idx_reg == IDX_W'(SIZE_MAX_BYTES - 1))
                        begin
                            err      = 1'b1;
                            err_code = ST_SIZE_LONG;
                        end
                        else if (in_last)
                        begin
                            err      = 1'b1;
                            err_code = ST_SIZE_TRUNC;
                        end
                        else
                        begin
                            idx_next = IDX_W'(idx_reg + IDX_W'(1));
                        end
                    end
                    else if (too_big)
                    begin
                        err      = 1'b1;
                        err_code = ST_OVERRUN;
                    end
                    else
                    begin
                        ppos_next = off_inc;
                        rem_next  = POS_WIDTH'(acc_upd);
                        if (acc_upd == '0)
                        begin
                            done = 1'b1;
                        end
                        else if (in_last)
                        begin
                            err      = 1'b1;
                            err_code = ST_OVERRUN;
                        end
                        else
                        begin
                            phase_next = PH_PAY;
                        end
                    end
                end
                PH_PAY:
                begin
                    rem_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        done = 1'b1;
                    end
                    else if (in_last)
                    begin
                        err      = 1'b1;
                        err_code = ST_OVERRUN;
                    end
                end
                default:
                begin
                end
            endcase

            if (err)
            begin
                phase_next              = PH_DRAIN;
                step.count              = 2'd1;
                step.r0.status          = err_code;
                step.r0.obu_type        = type_next;
                step.r0.header_pos      = 32'(hpos_next);
                step.r0.header_len      = hlen_next;
                step.r0.final_result    = 1'b1;
            end
            else if (done)
            begin
                phase_next              = PH_HDR;
                step.count              = in_last ? 2'd2 : 2'd1;
                step.r0.status          = ST_OBU;
                step.r0.obu_type        = type_next;
                step.r0.header_pos      = 32'(hpos_next);
                step.r0.header_len      = hlen_next;
                step.r0.payload_pos     = 32'(ppos_next);
                step.r0.payload_len     = 32'(acc_next);
                step.r1.status          = ST_OK;
                step.r1.final_result    = 1'b1;
            end

            if (in_last)
            begin
                phase_next  = PH_HDR;
                offset_next = '0;
            end
            else
            begin
                offset_next = off_inc;
            end
        end
    end

    a_pair_is_clean_end : assert property (@(posedge clk) disable iff (!rst_n)
        (step.count == 2'd2) |-> (in_last && step.r1.status == ST_OK
                                  && step.r1.final_result))
        else $error("second result is not a clean end");

    a_final_iff_not_obu : assert property (@(posedge clk) disable iff (!rst_n)
        (step.count != 2'd0) |-> ((step.r0.status == ST_OBU) == !step.r0.final_result))
        else $error("first result final flag disagrees with status");

    a_last_resets_offset : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_last) |=> (offset_reg == '0 && phase_reg == PH_HDR))
        else $error("stream end did not restart parsing");

endmodule

`default_nettype wire

// ----- sv/obuss_result_fifo.sv -----
// ----------------------------------------------------------------------------
// obuss_result_fifo
// Small result queue, up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module obuss_result_fifo #(
    parameter int DEPTH = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [1:0]                  wr_count,
    input  obuss_pkg::result_t               wr_data0,
    input  obuss_pkg::result_t               wr_data1,
    output logic                             rd_valid,
    input  wire logic                        rd_ready,
    output obuss_pkg::result_t               rd_data,
    output logic [$clog2(DEPTH+1)-1:0]       level
);
    import obuss_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH + 1);

    result_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0]   level_reg, level_next;
    logic               pop;
    logic [PTR_W-1:0]   wr_ptr_inc;

    assign rd_valid   = (level_reg != '0);
    assign rd_data    = mem_reg[rd_ptr_reg];
    assign level      = level_reg;
    assign pop        = rd_valid && rd_ready;
    assign wr_ptr_inc = PTR_W'(wr_ptr_reg + PTR_W'(1));

    always_comb
    begin
        wr_ptr_next = PTR_W'(wr_ptr_reg + PTR_W'(wr_count));
        rd_ptr_next = pop ? PTR_W'(rd_ptr_reg + PTR_W'(1)) : rd_ptr_reg;
        level_next  = LVL_W'(level_reg + LVL_W'(wr_count) - LVL_W'(pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= wr_data0;
        end
        if (wr_count == 2'd2)
        begin
            mem_reg[wr_ptr_inc] <= wr_data1;
        end
    end

endmodule

`default_nettype wire

// ----- sv/av1_obu_stream_splitter_unit.sv -----
// ----------------------------------------------------------------------------
// av1_obu_stream_splitter_unit
// Splits an AV1 low-overhead bitstream into OBU descriptors and stream status.
//
//  channel  dir  payload                                          end marker
//  s_*      in   tdata: data_byte                                 tlast: last_byte
//  m_*      out  tuser: status; tdata: obu_type, header_pos,      tlast: final_result
//                header_len, payload_pos, payload_len
//
// One byte per cycle while s_tready is high; a byte is registered, parsed in the next cycle, and its
// results (zero, one, or two on a clean stream end) are queued for m_*.
// Results queue in an 8-entry buffer; s_tready drops only when that buffer
// cannot take two more results from the byte in flight and the next one.
// Reset restarts parsing at offset zero with an empty result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module av1_obu_stream_splitter_unit #(
    parameter int POS_WIDTH      = 32,
    parameter int SIZE_MAX_BYTES = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,   // [7:0] data_byte
    input  wire logic                                s_tlast,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [3:0] obu_type, [35:4] header_pos, [37:36] header_len,
    // [69:38] payload_pos, [101:70] payload_len, [103:102] zero
    output logic [obuss_pkg::OUT_TDATA_W-1:0]        m_tdata,
    output logic [2:0]                               m_tuser,   // [2:0] status
    output logic                                     m_tlast
);
    import obuss_pkg::*;

    localparam int LVL_W = $clog2(RES_FIFO_DEPTH + 1);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    step_out_t   step;
    result_t     head;
    logic [LVL_W-1:0] level;
    logic [LVL_W+1:0] need;

    // room for the byte in flight plus the one accepted now
    assign need = (LVL_W+2)'(level) + (in_valid_reg ? (LVL_W+2)'(2) : '0)
                + (LVL_W+2)'(2);
    assign s_tready      = (need <= (LVL_W+2)'(RES_FIFO_DEPTH));
    assign in_valid_next = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_next)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    obuss_parser #(
        .POS_WIDTH      (POS_WIDTH),
        .SIZE_MAX_BYTES (SIZE_MAX_BYTES)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid_reg),
        .in_byte  (in_byte_reg),
        .in_last  (in_last_reg),
        .step     (step)
    );

    obuss_result_fifo #(
        .DEPTH (RES_FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_count (step.count),
        .wr_data0 (step.r0),
        .wr_data1 (step.r1),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (head),
        .level    (level)
    );

    assign m_tdata = {2'b00, head.payload_len, head.payload_pos, head.header_len,
                      head.header_pos, head.obu_type};
    assign m_tuser = head.status;
    assign m_tlast = head.final_result;

    a_room_for_results : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |-> (int'(level) + 2 <= RES_FIFO_DEPTH))
        else $error("result buffer may overflow");

    a_accept_enters_stage : assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted byte not staged");

    a_no_phantom_byte : assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tvalid && s_tready) |=> (!in_valid_reg && step.count == 2'd0))
        else $error("results without an accepted byte");

endmodule

`default_nettype wire

// ----- tb/av1_obu_stream_splitter_unit_tb.sv -----
// ----------------------------------------------------------------------------
// av1_obu_stream_splitter_unit_tb
// Drives directed and random OBU streams into the splitter: clean streams,
// truncated ones, corrupted headers and size fields, and plain noise. Source
// idle and sink stall vary by phase. Every output beat is checked against
// a local model of the parser.
// ----------------------------------------------------------------------------

module av1_obu_stream_splitter_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import obuss_pkg::*;

    localparam int          SIZE_BYTES = 8;
    localparam logic [55:0] SIZE_LIMIT = 56'hFFFF_FFFF;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } stream_byte_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata  = 8'd0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [2:0]             m_tuser;
    logic                   m_tlast;

    av1_obu_stream_splitter_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    stream_byte_t byte_q [$];
    result_t      desc_q [$];
    logic [7:0]   obu_bytes [$];
    int           idle_mode  = 0;
    int           n_err      = 0;
    logic         beat_taken = 1'b0;

    // parser model state
    phase_t      prs_phase  = PH_HDR;
    logic [31:0] prs_off    = '0;
    logic [3:0]  prs_type   = '0;
    logic [31:0] prs_hpos   = '0;
    logic [1:0]  prs_hlen   = 2'd1;
    logic [55:0] prs_acc    = '0;
    logic [2:0]  prs_idx    = '0;
    logic [55:0] prs_left   = '0;
    logic [31:0] prs_ppos   = '0;
    logic        prs_nosize = 1'b0;

    // {last, data}
    logic [8:0] dir_seq [27] = '{
        9'h012, 9'h100,                                 // empty OBU, clean end
        9'h00E, 9'h0FF, 9'h002, 9'h0AA, 9'h155,         // extension, 2-byte payload
        9'h1FE,                                         // extension on last beat
        9'h030, 9'h100,                                 // size flag clear
        9'h07C, 9'h100,                                 // size flag clear, extension
        9'h132,                                         // stream ends before size
        9'h00A, 9'h180,                                 // leb128 cut short
        9'h00A, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,         // leb128 too long, last on
        9'h0FF, 9'h0FF, 9'h0FF, 9'h1FF,                 // the eighth size byte
        9'h00A, 9'h003, 9'h111                          // stream ends in payload
    };

    task automatic put_byte(logic [7:0] b);
        obu_bytes.insert(obu_bytes.size(), b);
    endtask

    task automatic put_desc(result_t r);
        desc_q.insert(desc_q.size(), r);
    endtask

    task automatic put_beat(stream_byte_t sb);
        byte_q.insert(byte_q.size(), sb);
    endtask

    function automatic result_t make_desc(status_t st, logic [3:0] ty, logic [31:0] hp,
                                          logic [1:0] hl, logic [31:0] pp,
                                          logic [31:0] pl, logic fin);
        result_t r;
        r.status       = st;
        r.obu_type     = ty;
        r.header_pos   = hp;
        r.header_len   = hl;
        r.payload_pos  = pp;
        r.payload_len  = pl;
        r.final_result = fin;
        return r;
    endfunction

    function automatic string fmt_desc(result_t r);
        return $sformatf("st=%0d ty=%0d hpos=%0d hlen=%0d ppos=%0d plen=%0d fin=%0d",
                         r.status, r.obu_type, r.header_pos, r.header_len,
                         r.payload_pos, r.payload_len, r.final_result);
    endfunction

    task automatic count_error(string msg);
        n_err++;
        if (n_err <= 10)
            $display("%s", msg);
    endtask

    task automatic split_byte(logic [7:0] b, logic last);
        status_t err;
        logic    done;
        err  = ST_OBU;
        done = 1'b0;
        case (prs_phase)
            PH_HDR:
            begin
                prs_type   = b[6:3];
                prs_hpos   = prs_off;
                prs_hlen   = b[2] ? 2'd2 : 2'd1;
                prs_nosize = ~b[1];
                prs_acc    = '0;
                prs_idx    = '0;
                if (b[2])
                begin
                    if (last)
                        err = ST_HDR_TRUNC;
                    else
                        prs_phase = PH_EXT;
                end
                else if (prs_nosize)
                    err = ST_NO_SIZE;
                else if (last)
                    err = ST_SIZE_TRUNC;
                else
                    prs_phase = PH_SIZE;
            end
            PH_EXT:
            begin
                if (prs_nosize)
                    err = ST_NO_SIZE;
                else if (last)
                    err = ST_SIZE_TRUNC;
                else
                    prs_phase = PH_SIZE;
            end
            PH_SIZE:
            begin
                prs_acc = prs_acc | (56'(b[6:0]) << (7 * prs_idx));
                if (b[7])
                begin
                    // too long wins over truncation on the same beat
                    if (int'(prs_idx) + 1 >= SIZE_BYTES)
                        err = ST_SIZE_LONG;
                    else if (last)
                        err = ST_SIZE_TRUNC;
                    else
                        prs_idx = prs_idx + 3'd1;
                end
                else if (prs_acc > SIZE_LIMIT)
                    err = ST_OVERRUN;
                else
                begin
                    prs_ppos = prs_off + 32'd1;
                    prs_left = prs_acc;
                    if (prs_acc == '0)
                        done = 1'b1;
                    else if (last)
                        err = ST_OVERRUN;
                    else
                        prs_phase = PH_PAY;
                end
            end
            PH_PAY:
            begin
                prs_left = prs_left - 56'd1;
                if (prs_left == '0)
                    done = 1'b1;
                else if (last)
                    err = ST_OVERRUN;
            end
            default:
            begin
            end
        endcase

        if (err != ST_OBU)
        begin
            put_desc(make_desc(err, prs_type, prs_hpos, prs_hlen,
                               32'd0, 32'd0, 1'b1));
            prs_phase = PH_DRAIN;
        end
        else if (done)
        begin
            put_desc(make_desc(ST_OBU, prs_type, prs_hpos, prs_hlen,
                               prs_ppos, prs_acc[31:0], 1'b0));
            prs_phase = PH_HDR;
            if (last)
                put_desc(make_desc(ST_OK, 4'd0, 32'd0, 2'd0,
                                   32'd0, 32'd0, 1'b1));
        end

        if (last)
        begin
            prs_phase = PH_HDR;
            prs_off   = '0;
        end
        else
            prs_off = prs_off + 32'd1;
    endtask

    // leb128 with optional non-minimal padding, never past eight bytes
    task automatic put_leb(logic [55:0] v, int pad);
        int g;
        g = 1;
        while (g < SIZE_BYTES && (v >> (7 * g)) != '0)
            g++;
        g = (g + pad > SIZE_BYTES) ? SIZE_BYTES : g + pad;
        for (int i = 0; i < g; i++)
            put_byte({i < g - 1, 7'(v >> (7 * i))});
    endtask

    // flavor: 0 clean, 1 size flag clear, 2 overlong size, 3 size past 32 bits
    task automatic add_obu(int plen, int flavor);
        logic [7:0] hdr;
        hdr    = 8'($urandom);
        hdr[1] = (flavor != 1);
        put_byte(hdr);
        if (hdr[2])
            put_byte(8'($urandom));
        case (flavor)
            1: repeat ($urandom_range(0, 3)) put_byte(8'($urandom));
            2: repeat ($urandom_range(8, 9)) put_byte(8'($urandom) | 8'h80);
            3:
            begin
                put_leb({24'($urandom_range(1, 24'hFF_FFFF)), 32'($urandom)}, 0);
                repeat ($urandom_range(0, 3)) put_byte(8'($urandom));
            end
            default:
            begin
                put_leb(56'(plen), ($urandom_range(0, 9) == 0) ? $urandom_range(1, 7) : 0);
                repeat (plen) put_byte(8'($urandom));
            end
        endcase
    endtask

    task automatic add_stream(output int n_bytes);
        int kind;
        int n_obu;
        int bad_at;
        int flavor;
        int plen;
        int cut;
        obu_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            repeat ($urandom_range(1, 6)) put_byte(8'($urandom));
        end
        else
        begin
            n_obu  = $urandom_range(1, 4);
            bad_at = (kind < 23) ? $urandom_range(0, n_obu - 1) : -1;
            for (int i = 0; i < n_obu; i++)
            begin
                plen   = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 60)
                                                     : $urandom_range(0, 6);
                flavor = (i == bad_at) ? $urandom_range(1, 3) : 0;
                add_obu(plen, flavor);
                if (flavor != 0)
                    break;
            end
        end
        cut = obu_bytes.size() - 1;
        if (kind >= 23 && kind < 45)
            cut = $urandom_range(0, obu_bytes.size() - 1);
        for (int i = 0; i <= cut; i++)
            put_beat({i == cut, obu_bytes[i]});
        n_bytes = cut + 1;
    endtask

    function automatic logic src_gap();
        int roll;
        roll = $urandom_range(0, 99);
        return (idle_mode == 1 && roll < 87) || (idle_mode == 3 && roll < 31);
    endfunction

    function automatic logic sink_hold();
        int roll;
        roll = $urandom_range(0, 99);
        return (idle_mode == 2 && roll < 87) || (idle_mode == 3 && roll < 31);
    endfunction

    // sender holds off until the byte queue, the bus and the expected results are empty
    task automatic wait_drained();
        do
            @(negedge clk);
        while (byte_q.size() != 0 || s_tvalid || desc_q.size() != 0);
    endtask

    initial
    begin
        forever #6 clk = ~clk;
    end

    // driver
    always @(negedge clk)
    begin
        stream_byte_t nb;
        if (rst_n)
        begin
            if (!s_tvalid || beat_taken)
            begin
                if (byte_q.size() != 0 && !src_gap())
                begin
                    nb = byte_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nb.data;
                    s_tlast  <= nb.last;
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= !sink_hold();
        end
    end

    // input beats feed the model; output beats are checked in order
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        beat_taken <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                split_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                got.status       = status_t'(m_tuser);
                got.obu_type     = m_tdata[3:0];
                got.header_pos   = m_tdata[35:4];
                got.header_len   = m_tdata[37:36];
                got.payload_pos  = m_tdata[69:38];
                got.payload_len  = m_tdata[101:70];
                got.final_result = m_tlast;
                if (desc_q.size() == 0)
                    count_error($sformatf("unexpected beat: %s", fmt_desc(got)));
                else
                begin
                    want = desc_q.pop_front();
                    if (got !== want || m_tdata[OUT_TDATA_W-1:102] !== '0)
                        count_error($sformatf("mismatch: expected %s, got %s pad=%0h",
                                              fmt_desc(want), fmt_desc(got),
                                              m_tdata[OUT_TDATA_W-1:102]));
                end
            end
        end
    end

    initial
    begin
        int n;
        int n_fed;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        idle_mode = 0;
        foreach (dir_seq[i])
            put_beat(stream_byte_t'(dir_seq[i]));
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_mode = ph;
            n_fed     = 0;
            while (n_fed < 270)
            begin
                add_stream(n);
                n_fed += n;
            end
            wait_drained();
        end

        repeat (20) @(negedge clk);
        if (desc_q.size() != 0)
            count_error($sformatf("%0d results never arrived", desc_q.size()));
        if (n_err == 0)
            $display("av1_obu_stream_splitter_unit_tb: done, clean");
        else
            $display("av1_obu_stream_splitter_unit_tb: done, errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #7_200_000;
        $display("av1_obu_stream_splitter_unit_tb: done, errors");
        $finish;
    end

endmodule
